// ===== design/gme_pkg.sv =====
// ----------------------------------------------------------------------------
// gme_pkg: shared types and constants of the gradient magnitude edge map
// Field widths, register codes, the queue size and the item that travels
// from the line-store front end to the result back end.
// ----------------------------------------------------------------------------
package gme_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 13;
  localparam int COORD_W     = 12;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [PIX_W-1:0] MAG_MAX      = 8'd255;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } gme_reg_t;

  typedef enum logic [1:0] {
    KIND_ABOVE,
    KIND_ROW_LEFT,
    KIND_FLUSH
  } gme_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [PIX_W-1:0]   a_left;
    logic [PIX_W-1:0]   a_center;
    logic [PIX_W-1:0]   a_right;
    logic [PIX_W-1:0]   b_center;
    logic [PIX_W-1:0]   rec0;
    logic [PIX_W-1:0]   rec1;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               r_ge1;
    logic               r_ge2;
    logic               c_ge1;
    logic               c_ge2;
    logic               last_col;
    logic               last_row;
  } gme_item_t;

endpackage

// ===== design/gme_front.sv =====
// ----------------------------------------------------------------------------
// gme_front: pixel intake, position counters and line store
// Tracks the raster position, keeps the two rows above in one line store
// and hands each pixel owed a result, with its neighborhood, to the result queue.
// ----------------------------------------------------------------------------
module gme_front
  import gme_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] frame_width,
  input  logic [CFG_W-1:0] frame_height,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  output logic             push_valid,
  output gme_item_t        push_item
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int HCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [PIX_W-1:0]   rec0;
  logic [PIX_W-1:0]   rec1;
  logic [WCMP_W-1:0]  col_p1;
  logic [HCMP_W-1:0]  row_p1;
  logic               last_col;
  logic               last_row;
  logic [COL_W-1:0]   right_addr;

  logic               s1_valid;
  logic [COL_W-1:0]   s1_addr;
  gme_item_t          s1_item;
  logic [2*PIX_W-1:0] q_center;
  logic [2*PIX_W-1:0] q_right;
  logic [2*PIX_W-1:0] wr_data;
  logic [PIX_W-1:0]   a_last;

  assign col_p1   = WCMP_W'(col) + WCMP_W'(1);
  assign row_p1   = HCMP_W'(row) + HCMP_W'(1);
  assign last_col = (col_p1 >= WCMP_W'(frame_width)) || (col_p1 >= WCMP_W'(MAX_WIDTH));
  assign last_row = (row_p1 >= HCMP_W'(frame_height)) || (row_p1 >= HCMP_W'(MAX_HEIGHT));
  assign right_addr = last_col ? col : col + COL_W'(1);

  // Each word holds the older row in the upper byte and the previous row below.
  assign wr_data = {q_center[PIX_W-1:0], s1_item.pixel};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_addr] <= wr_data;
    end
    if (accept) begin
      if (s1_valid && (s1_addr == col)) begin
        q_center <= wr_data;
      end else begin
        q_center <= line_mem[col];
      end
      if (s1_valid && (s1_addr == right_addr)) begin
        q_right <= wr_data;
      end else begin
        q_right <= line_mem[right_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      rec0     <= '0;
      rec1     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        rec1 <= rec0;
        rec0 <= pixel;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr           <= col;
      s1_item.pixel     <= pixel;
      s1_item.a_left    <= '0;
      s1_item.a_center  <= '0;
      s1_item.a_right   <= '0;
      s1_item.b_center  <= '0;
      s1_item.rec0      <= rec0;
      s1_item.rec1      <= rec1;
      s1_item.col       <= COORD_W'(col);
      s1_item.row       <= COORD_W'(row);
      s1_item.r_ge1     <= (row != '0);
      s1_item.r_ge2     <= (row > ROW_W'(1));
      s1_item.c_ge1     <= (col != '0);
      s1_item.c_ge2     <= (col > COL_W'(1));
      s1_item.last_col  <= last_col;
      s1_item.last_row  <= last_row;
    end
    if (s1_valid) begin
      a_last <= q_center[PIX_W-1:0];
    end
  end

  always_comb begin
    push_item          = s1_item;
    push_item.a_left   = a_last;
    push_item.a_center = q_center[PIX_W-1:0];
    push_item.a_right  = q_right[PIX_W-1:0];
    push_item.b_center = q_center[2*PIX_W-1:PIX_W];
  end

  assign push_valid = s1_valid && (s1_item.r_ge1 ||
                      (s1_item.last_row && (s1_item.c_ge1 || s1_item.last_col)));

endmodule

// ===== design/gme_queue.sv =====
// ----------------------------------------------------------------------------
// gme_queue: item queue between front end and back end
// A small register queue that lets the intake run on while the back end
// emits the extra results of the final row.
// ----------------------------------------------------------------------------
module gme_queue
  import gme_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  gme_item_t         push_item,
  input  logic              pop,
  output logic              head_valid,
  output gme_item_t         head_item,
  output logic [QCNT_W-1:0] count
);

  gme_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_valid) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

endmodule

// ===== design/gme_back.sv =====
// ----------------------------------------------------------------------------
// gme_back: result sequencing and gradient magnitude
// Walks through the one to three results of the item at the queue head,
// computes the saturated squared gradient and holds it in the output register.
// ----------------------------------------------------------------------------
module gme_back
  import gme_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  gme_item_t          head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   edge_value,
  output logic [COORD_W-1:0] out_column,
  output logic [COORD_W-1:0] out_row,
  output logic               last_of_run,
  output logic               end_of_frame
);

  logic [2:0]             done;
  logic [2:0]             need;
  logic [2:0]             cur_bit;
  gme_kind_t              kind;
  logic                   run_last;
  logic                   load;

  logic [PIX_W-1:0]       left;
  logic [PIX_W-1:0]       right;
  logic [PIX_W-1:0]       up;
  logic [PIX_W-1:0]       down;
  logic [COORD_W-1:0]     res_col;
  logic [COORD_W-1:0]     res_row;
  logic                   res_eof;

  logic signed [PIX_W:0]  dx;
  logic signed [PIX_W:0]  dy;
  logic signed [PIX_W:0]  dx_adj;
  logic signed [PIX_W:0]  dy_adj;
  logic signed [PIX_W-1:0] gx;
  logic signed [PIX_W-1:0] gy;
  logic [2*PIX_W-1:0]     sqx;
  logic [2*PIX_W-1:0]     sqy;
  logic [2*PIX_W:0]       sum;
  logic [PIX_W-1:0]       mag;

  assign need = {head_item.last_row & head_item.last_col,
                 head_item.last_row & head_item.c_ge1,
                 head_item.r_ge1} & ~done;

  always_comb begin
    priority if (need[0]) begin
      kind = KIND_ABOVE;
    end else if (need[1]) begin
      kind = KIND_ROW_LEFT;
    end else begin
      kind = KIND_FLUSH;
    end
  end

  always_comb begin
    unique case (kind)
      KIND_ABOVE: begin
        cur_bit = 3'b001;
        left    = head_item.c_ge1 ? head_item.a_left : head_item.a_center;
        right   = head_item.last_col ? head_item.a_center : head_item.a_right;
        up      = head_item.r_ge2 ? head_item.b_center : head_item.a_center;
        down    = head_item.pixel;
        res_col = head_item.col;
        res_row = head_item.row - COORD_W'(1);
        res_eof = 1'b0;
      end
      KIND_ROW_LEFT: begin
        cur_bit = 3'b010;
        left    = head_item.c_ge2 ? head_item.rec1 : head_item.rec0;
        right   = head_item.pixel;
        up      = head_item.r_ge1 ? head_item.a_left : head_item.rec0;
        down    = head_item.rec0;
        res_col = head_item.col - COORD_W'(1);
        res_row = head_item.row;
        res_eof = 1'b0;
      end
      KIND_FLUSH: begin
        cur_bit = 3'b100;
        left    = head_item.c_ge1 ? head_item.rec0 : head_item.pixel;
        right   = head_item.pixel;
        up      = head_item.r_ge1 ? head_item.a_center : head_item.pixel;
        down    = head_item.pixel;
        res_col = head_item.col;
        res_row = head_item.row;
        res_eof = 1'b1;
      end
      default: begin
        cur_bit = 3'b000;
        left    = '0;
        right   = '0;
        up      = '0;
        down    = '0;
        res_col = '0;
        res_row = '0;
        res_eof = 1'b0;
      end
    endcase
  end

  // Halving by the shift rounds down, so negative differences are bumped by one first to round toward zero.
  always_comb begin
    dx     = $signed({1'b0, right}) - $signed({1'b0, left});
    dy     = $signed({1'b0, down}) - $signed({1'b0, up});
    dx_adj = dx + $signed({{PIX_W{1'b0}}, dx[PIX_W]});
    dy_adj = dy + $signed({{PIX_W{1'b0}}, dy[PIX_W]});
    gx     = dx_adj[PIX_W:1];
    gy     = dy_adj[PIX_W:1];
    sqx    = gx * gx;
    sqy    = gy * gy;
    sum    = {1'b0, sqx} + {1'b0, sqy};
    mag    = (sum > (2*PIX_W+1)'(MAG_MAX)) ? MAG_MAX : sum[PIX_W-1:0];
  end

  assign run_last = ((need & ~cur_bit) == 3'b000);
  assign load     = head_valid && (!out_valid || !out_stall);
  assign pop      = load && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= run_last ? 3'b000 : (done | cur_bit);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      edge_value   <= mag;
      out_column   <= res_col;
      out_row      <= res_row;
      last_of_run  <= run_last;
      end_of_frame <= res_eof;
    end
  end

endmodule

// ===== design/gradient_magnitude_edge_map.sv =====
// ----------------------------------------------------------------------------
// gradient_magnitude_edge_map: streaming squared gradient edge map
// Central differences over a raster frame with replicated borders; results
// for each row appear while the next row streams in.
//
// Channel  Dir  Handshake                   Payload
// config   in   psel, penable, pready       paddr, pwdata, prdata
// pixels   in   in_valid, in_stall          pixel
// edges    out  out_valid, out_stall        edge_value, out_column, out_row,
//                                           last_of_run, end_of_frame
//
// One pixel is taken per cycle while in_stall is low. On the final row the
// output port carries one result per cycle while out_stall is low; most
// pixels there yield two results and the frame's last pixel three. Reset is
// synchronous and needs no clearing pass; the line store is undefined until
// written. in_stall rises in reset and when the four-entry result queue and
// the line-store read stage are full; out_stall holds the output register.
// ----------------------------------------------------------------------------
module gradient_magnitude_edge_map
  import gme_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   edge_value,
  output logic [COORD_W-1:0] out_column,
  output logic [COORD_W-1:0] out_row,
  output logic               last_of_run,
  output logic               end_of_frame
);

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  gme_reg_t          reg_sel;
  logic              cfg_write;
  logic              accept;
  logic              push_valid;
  gme_item_t         push_item;
  logic              pop;
  logic              head_valid;
  gme_item_t         head_item;
  logic [QCNT_W-1:0] q_count;

  assign pready    = 1'b1;
  assign reg_sel   = gme_reg_t'(paddr[ADDR_W-1]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
    endcase
  end

  assign in_stall = rst || (push_valid ? (q_count >= QCNT_W'(QUEUE_DEPTH - 1))
                                       : (q_count >= QCNT_W'(QUEUE_DEPTH)));
  assign accept   = in_valid && !in_stall;

  gme_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .accept       (accept),
    .pixel        (pixel),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  gme_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  gme_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .edge_value   (edge_value),
    .out_column   (out_column),
    .out_row      (out_row),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

endmodule

// ===== design/gme_checker.sv =====
// ----------------------------------------------------------------------------
// gme_checker: port-level checks of the edge map
// Watches the result channel for reset behavior, held transfers and the
// grouping of results into runs.
// ----------------------------------------------------------------------------
module gme_checker
  import gme_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PIX_W-1:0]   edge_value,
  input logic [COORD_W-1:0] out_column,
  input logic [COORD_W-1:0] out_row,
  input logic               last_of_run,
  input logic               end_of_frame
);

  a_reset_idle: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("Result offered right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({edge_value, out_column, out_row, last_of_run, end_of_frame}))
    else $error("Stalled result changed or vanished.");

  a_frame_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_of_run)
    else $error("Frame end inside a run.");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("Run broken off after a transfer.");

endmodule

bind gradient_magnitude_edge_map gme_checker u_checker (.*);
